>>> sv/mfq_pkg.sv
// ----------------------------------------------------------------------------
// mfq_pkg
// Types, codes and constants shared by the mains frequency qualifier.
// ----------------------------------------------------------------------------
package mfq_pkg;

    localparam int unsigned FREQ_W     = 14;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned HZ_W       = 6;
    localparam int unsigned SRC_W      = 2;
    localparam int unsigned HALF_W     = 14;
    localparam int unsigned TICKS_W    = 7;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 6;

    localparam logic [FREQ_W-1:0] FREQ_MIN_CHZ   = 14'd4500;
    localparam logic [FREQ_W-1:0] FREQ_MAX_CHZ   = 14'd6500;
    localparam logic [FREQ_W-1:0] FREQ_SPLIT_CHZ = 14'd5500;

    localparam logic [TIME_W-1:0] STALE_MS    = 32'd30000;
    localparam logic [TIME_W-1:0] MISMATCH_MS = 32'd60000;

    localparam logic [HZ_W-1:0] HZ_50 = 6'd50;
    localparam logic [HZ_W-1:0] HZ_60 = 6'd60;

    localparam logic [HALF_W-1:0]  HALF_US_50 = 14'd10000;
    localparam logic [HALF_W-1:0]  HALF_US_60 = 14'd8333;
    localparam logic [TICKS_W-1:0] TICKS_50   = 7'd98;
    localparam logic [TICKS_W-1:0] TICKS_60   = 7'd81;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MANUAL_MODE = 1'b0,
        CFG_MANUAL_HZ   = 1'b1
    } mfq_cfg_idx_t;

    typedef enum logic [SRC_W-1:0] {
        SRC_FALLBACK = 2'd0,
        SRC_METER    = 2'd1,
        SRC_MANUAL   = 2'd2
    } mfq_src_t;

    typedef struct packed {
        logic [FREQ_W-1:0] freq_centihz;
        logic [TIME_W-1:0] now_ms;
    } mfq_in_t;

    typedef struct packed {
        logic [HZ_W-1:0]    effective_hz;
        logic [SRC_W-1:0]   freq_source;
        logic               mismatch_warning;
        logic [HALF_W-1:0]  half_period_us;
        logic [TICKS_W-1:0] max_delay_ticks;
    } mfq_out_t;

    function automatic logic [HZ_W-1:0] hz_of(input logic is_60);
        return is_60 ? HZ_60 : HZ_50;
    endfunction

    function automatic logic [HALF_W-1:0] half_us_of(input logic is_60);
        return is_60 ? HALF_US_60 : HALF_US_50;
    endfunction

    function automatic logic [TICKS_W-1:0] ticks_of(input logic is_60);
        return is_60 ? TICKS_60 : TICKS_50;
    endfunction

endpackage

>>> sv/mains_frequency_qualifier_unit.sv
// ----------------------------------------------------------------------------
// mains_frequency_qualifier_unit
// Qualifies meter frequency reports and selects the mains frequency in use.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one report (centihertz, ms timestamp).
//   m_valid/m_ready/m_data carry one result per report: frequency in use,
//   its source, the mismatch warning, half period and triac delay ticks.
//   cfg_wr_en/cfg_addr/cfg_wdata write manual_mode (0) and manual_hz (1);
//   write only while no transaction is in flight.
//   m_valid rises when a report moves from the input to the result register.
//   Throughput: one report per cycle while the receiver does not stall; the
//   state update is a single pass of compares and one 32-bit subtract per
//   timer between the input register and the result register.
//   When the receiver stalls, the result register holds and the input
//   register keeps one more report; s_ready drops once both are full.
//   Reset (aresetn low, synchronous) empties both registers and returns the
//   state to 50 Hz, fallback source, timer idle, warning clear.
// ----------------------------------------------------------------------------
module mains_frequency_qualifier_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  mfq_pkg::mfq_in_t                    s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output mfq_pkg::mfq_out_t                   m_data,
    input  logic                                cfg_wr_en,
    input  logic [mfq_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [mfq_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import mfq_pkg::*;

    logic              manual_mode_reg;
    logic              manual_60_reg;

    logic              in_valid_reg;
    mfq_in_t           in_data_reg;
    logic              m_valid_reg;
    mfq_out_t          m_data_reg;

    logic [TIME_W-1:0] last_valid_reg, last_valid_next;
    logic [TIME_W-1:0] mm_start_reg, mm_start_next;
    logic              hz60_reg, hz60_next;
    mfq_src_t          source_reg, source_next;
    logic              warn_reg, warn_next;

    logic              advance;
    logic              plausible;
    logic              meter_60;
    logic [TIME_W-1:0] start_eff;
    logic [TIME_W-1:0] stale_age;
    logic [TIME_W-1:0] mm_age;

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign plausible = (in_data_reg.freq_centihz >= FREQ_MIN_CHZ)
                    && (in_data_reg.freq_centihz <= FREQ_MAX_CHZ);
    assign meter_60  = (in_data_reg.freq_centihz >= FREQ_SPLIT_CHZ);
    assign start_eff = (mm_start_reg == '0) ? in_data_reg.now_ms : mm_start_reg;
    assign stale_age = in_data_reg.now_ms - last_valid_reg;
    assign mm_age    = in_data_reg.now_ms - start_eff;

    always_comb begin
        last_valid_next = last_valid_reg;
        mm_start_next   = mm_start_reg;
        hz60_next       = hz60_reg;
        source_next     = source_reg;
        warn_next       = warn_reg;
        if (manual_mode_reg) begin
            hz60_next   = manual_60_reg;
            source_next = SRC_MANUAL;
            warn_next   = 1'b0;
        end else if (!plausible) begin
            if (stale_age > STALE_MS) begin
                hz60_next   = manual_60_reg;
                source_next = SRC_FALLBACK;
            end
        end else begin
            last_valid_next = in_data_reg.now_ms;
            hz60_next       = meter_60;
            source_next     = SRC_METER;
            if (meter_60 != manual_60_reg) begin
                mm_start_next = start_eff;
                if (mm_age > MISMATCH_MS) begin
                    warn_next = 1'b1;
                end
            end else begin
                mm_start_next = '0;
                warn_next     = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            manual_mode_reg <= 1'b0;
            manual_60_reg   <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_MANUAL_MODE: manual_mode_reg <= cfg_wdata[0];
                CFG_MANUAL_HZ:   manual_60_reg   <= (cfg_wdata == HZ_60);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            last_valid_reg <= '0;
            mm_start_reg   <= '0;
            hz60_reg       <= 1'b0;
            source_reg     <= SRC_FALLBACK;
            warn_reg       <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg    <= 1'b1;
                last_valid_reg <= last_valid_next;
                mm_start_reg   <= mm_start_next;
                hz60_reg       <= hz60_next;
                source_reg     <= source_next;
                warn_reg       <= warn_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            m_data_reg.effective_hz     <= hz_of(hz60_next);
            m_data_reg.freq_source      <= source_next;
            m_data_reg.mismatch_warning <= warn_next;
            m_data_reg.half_period_us   <= half_us_of(hz60_next);
            m_data_reg.max_delay_ticks  <= ticks_of(hz60_next);
        end
    end

endmodule

>>> sv/mfq_checker.sv
// ----------------------------------------------------------------------------
// mfq_checker
// Port-level checks for the mains frequency qualifier, bound to the top level.
// ----------------------------------------------------------------------------
module mfq_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              m_valid,
    input  logic              m_ready,
    input  mfq_pkg::mfq_out_t m_data
);
    import mfq_pkg::*;

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_timing_50: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.effective_hz != HZ_60 |->
            m_data.effective_hz == HZ_50 && m_data.half_period_us == HALF_US_50
            && m_data.max_delay_ticks == TICKS_50)
        else $error("bad timing for 50 Hz");

    a_timing_60: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.effective_hz == HZ_60 |->
            m_data.half_period_us == HALF_US_60 && m_data.max_delay_ticks == TICKS_60)
        else $error("bad timing for 60 Hz");

    a_manual_no_warn: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.freq_source == SRC_MANUAL |-> !m_data.mismatch_warning)
        else $error("warning set in manual mode");

endmodule

bind mains_frequency_qualifier_unit mfq_checker u_mfq_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
